>>> hdl/bol_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bol_pkg;

  // default coordinate width of the line walker
  localparam int unsigned COORD_BITS_DEF = 12;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  // octant codes: the major axis is x for first and eighth, y for second and seventh
  typedef enum logic [1:0] {
    OCT_FIRST   = 2'd0,
    OCT_SECOND  = 2'd1,
    OCT_EIGHTH  = 2'd2,
    OCT_SEVENTH = 2'd3
  } octant_e;

endpackage

`default_nettype wire

>>> hdl/bol_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bol_in_if #(
  parameter int unsigned COORD_BITS = bol_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic [1:0]            octant;

  modport source (
    output valid, opcode, start_x, start_y, end_x, end_y, octant,
    input  ready
  );

  modport sink (
    input  valid, opcode, start_x, start_y, end_x, end_y, octant,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/bol_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bol_out_if #(
  parameter int unsigned COORD_BITS = bol_pkg::COORD_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [COORD_BITS-1:0]      pixel_x;
  logic [COORD_BITS-1:0]      pixel_y;
  logic signed [COORD_BITS:0] steps_left;
  logic signed [COORD_BITS:0] span;
  logic                       last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, steps_left, span, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, steps_left, span, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/bresenham_octant_line_stepper.sv
`timescale 1ns / 1ps
`default_nettype none

// Integer line walker for the first, second, eighth and seventh octants.
// Input channel in_i: a start transaction (opcode 0) loads both endpoints and
// the octant and gives no pixel; a step transaction (opcode 1) emits the
// current pixel on out_o and advances the walker by one major-axis position.
// The end point is never emitted; the pixel before it carries last_pixel.
// A step while no line is in progress is taken and dropped, and a start
// during a line abandons it.
// Output: a pixel is registered and appears on out_o in the cycle after its step transaction.
// Throughput: one transaction per cycle while in_i.ready is high; the step
// datapath is two adds on the error term, walker registers to output register.
// Stalls: the output register holds its pixel while out_o.ready is low, and
// in_i.ready drops only while that register is full and not being taken.
// Reset: the walker is idle and the output register is empty.
module bresenham_octant_line_stepper #(
  parameter int unsigned COORD_BITS = bol_pkg::COORD_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bol_in_if.sink    in_i,
  bol_out_if.source out_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned TW = COORD_BITS + 2;
  localparam int unsigned EW = COORD_BITS + 3;

  // walker state
  logic [CW-1:0]    cur_x_q, cur_x_d;
  logic [CW-1:0]    cur_y_q, cur_y_d;
  logic [CW-1:0]    goal_x_q, goal_x_d;
  logic [CW-1:0]    goal_y_q, goal_y_d;
  logic [EW-1:0]    err_q, err_d;
  logic [TW-1:0]    tdx_q, tdx_d;
  logic [TW-1:0]    tdy_q, tdy_d;
  bol_pkg::octant_e mode_q, mode_d;
  logic             busy_q, busy_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [CW-1:0]    px_q, px_d;
  logic [CW-1:0]    py_q, py_d;
  logic [DW-1:0]    steps_q, steps_d;
  logic [DW-1:0]    span_q, span_d;
  logic             last_q, last_d;

  logic             in_acc;
  logic             is_step;
  logic             do_step;
  logic [DW-1:0]    load_dx;
  logic [DW-1:0]    load_dy;
  bol_pkg::octant_e load_mode;
  logic [CW-1:0]    st_x, st_y;
  logic [EW-1:0]    st_err;
  logic [DW-1:0]    st_steps, st_span;
  logic             active_d;
  logic             active_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_step    = (in_i.opcode == bol_pkg::OP_STEP);
  assign do_step    = in_acc && is_step && busy_q;
  assign load_mode  = bol_pkg::octant_e'(in_i.octant);
  assign load_dx    = {1'b0, in_i.end_x} - {1'b0, in_i.start_x};
  assign load_dy    = {1'b0, in_i.end_y} - {1'b0, in_i.start_y};

  bol_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .mode_i    (mode_q),
    .cur_x_i   (cur_x_q),
    .cur_y_i   (cur_y_q),
    .goal_x_i  (goal_x_q),
    .goal_y_i  (goal_y_q),
    .err_i     (err_q),
    .tdx_i     (tdx_q),
    .tdy_i     (tdy_q),
    .nxt_x_o   (st_x),
    .nxt_y_o   (st_y),
    .nxt_err_o (st_err),
    .steps_o   (st_steps),
    .span_o    (st_span)
  );

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    goal_x_d = goal_x_q;
    goal_y_d = goal_y_q;
    err_d    = err_q;
    tdx_d    = tdx_q;
    tdy_d    = tdy_q;
    mode_d   = mode_q;
    if (in_acc && !is_step) begin
      cur_x_d  = in_i.start_x;
      cur_y_d  = in_i.start_y;
      goal_x_d = in_i.end_x;
      goal_y_d = in_i.end_y;
      tdx_d    = {load_dx, 1'b0};
      tdy_d    = {load_dy, 1'b0};
      mode_d   = load_mode;
      if (load_mode == bol_pkg::OCT_SECOND || load_mode == bol_pkg::OCT_SEVENTH) begin
        err_d = {{2{load_dy[DW-1]}}, load_dy};
      end else begin
        err_d = {{2{load_dx[DW-1]}}, load_dx};
      end
    end else if (do_step) begin
      cur_x_d = st_x;
      cur_y_d = st_y;
      err_d   = st_err;
    end
  end

  // loop condition on the next walker state
  always_comb begin
    unique case (mode_d)
      bol_pkg::OCT_SECOND:  active_d = cur_y_d < goal_y_d;
      bol_pkg::OCT_SEVENTH: active_d = cur_y_d > goal_y_d;
      default:              active_d = cur_x_d < goal_x_d;
    endcase
  end

  assign busy_d = (in_acc && (!is_step || busy_q)) ? active_d : busy_q;

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    px_d        = px_q;
    py_d        = py_q;
    steps_d     = steps_q;
    span_d      = span_q;
    last_d      = last_q;
    if (do_step) begin
      out_valid_d = 1'b1;
      px_d        = cur_x_q;
      py_d        = cur_y_q;
      steps_d     = st_steps;
      span_d      = st_span;
      last_d      = !active_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      err_q       <= '0;
      tdx_q       <= '0;
      tdy_q       <= '0;
      mode_q      <= bol_pkg::OCT_FIRST;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      goal_x_q    <= goal_x_d;
      goal_y_q    <= goal_y_d;
      err_q       <= err_d;
      tdx_q       <= tdx_d;
      tdy_q       <= tdy_d;
      mode_q      <= mode_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q    <= px_d;
    py_q    <= py_d;
    steps_q <= steps_d;
    span_q  <= span_d;
    last_q  <= last_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.pixel_x    = px_q;
  assign out_o.pixel_y    = py_q;
  assign out_o.steps_left = steps_q;
  assign out_o.span       = span_q;
  assign out_o.last_pixel = last_q;

  // loop condition on the current state, for checking only
  always_comb begin
    unique case (mode_q)
      bol_pkg::OCT_SECOND:  active_q = cur_y_q < goal_y_q;
      bol_pkg::OCT_SEVENTH: active_q = cur_y_q > goal_y_q;
      default:              active_q = cur_x_q < goal_x_q;
    endcase
  end

  a_busy_means_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> active_q)
    else $error("walker busy with a finished line");

  a_step_gives_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_step |=> out_valid_q)
    else $error("step transaction on a live line gave no pixel");

  a_idle_step_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_step && !busy_q) |=> !out_valid_q)
    else $error("step transaction while idle produced a pixel");

  a_start_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !is_step) |=> !out_valid_q)
    else $error("start transaction produced a pixel");

endmodule

`default_nettype wire

>>> hdl/bol_step.sv
`timescale 1ns / 1ps
`default_nettype none

// one walker step: pixel report values and the advanced point and error
module bol_step #(
  parameter int unsigned COORD_BITS = bol_pkg::COORD_BITS_DEF
) (
  input  wire bol_pkg::octant_e        mode_i,
  input  wire logic [COORD_BITS-1:0]   cur_x_i,
  input  wire logic [COORD_BITS-1:0]   cur_y_i,
  input  wire logic [COORD_BITS-1:0]   goal_x_i,
  input  wire logic [COORD_BITS-1:0]   goal_y_i,
  input  wire logic [COORD_BITS+2:0]   err_i,
  input  wire logic [COORD_BITS+1:0]   tdx_i,
  input  wire logic [COORD_BITS+1:0]   tdy_i,
  output logic      [COORD_BITS-1:0]   nxt_x_o,
  output logic      [COORD_BITS-1:0]   nxt_y_o,
  output logic      [COORD_BITS+2:0]   nxt_err_o,
  output logic      [COORD_BITS:0]     steps_o,
  output logic      [COORD_BITS:0]     span_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned EW = COORD_BITS + 3;

  logic [EW-1:0] tdx_ext;
  logic [EW-1:0] tdy_ext;
  logic [EW-1:0] e_minor;
  logic [EW-1:0] e_major;
  logic          minor_step;
  logic          major_is_x;
  logic [CW-1:0] one_c;

  assign one_c      = {{(CW-1){1'b0}}, 1'b1};
  assign tdx_ext    = {tdx_i[CW+1], tdx_i};
  assign tdy_ext    = {tdy_i[CW+1], tdy_i};
  assign major_is_x = (mode_i == bol_pkg::OCT_FIRST) || (mode_i == bol_pkg::OCT_EIGHTH);

  always_comb begin
    if (major_is_x) begin
      steps_o = {1'b0, goal_x_i} - {1'b0, cur_x_i};
      span_o  = tdx_i[CW+1:1];
    end else begin
      steps_o = {1'b0, goal_y_i} - {1'b0, cur_y_i};
      span_o  = tdy_i[CW+1:1];
    end
  end

  always_comb begin
    nxt_x_o = cur_x_i;
    nxt_y_o = cur_y_i;
    e_minor = err_i;
    e_major = err_i;
    minor_step = 1'b0;
    unique case (mode_i)
      bol_pkg::OCT_FIRST: begin
        e_minor    = err_i - tdy_ext;
        e_major    = e_minor + tdx_ext;
        minor_step = e_minor[EW-1];
        nxt_x_o    = cur_x_i + one_c;
        if (minor_step) nxt_y_o = cur_y_i + one_c;
      end
      bol_pkg::OCT_SECOND: begin
        e_minor    = err_i - tdx_ext;
        e_major    = e_minor + tdy_ext;
        minor_step = e_minor[EW-1];
        nxt_y_o    = cur_y_i + one_c;
        if (minor_step) nxt_x_o = cur_x_i + one_c;
      end
      bol_pkg::OCT_EIGHTH: begin
        e_minor    = err_i + tdy_ext;
        e_major    = e_minor + tdx_ext;
        minor_step = e_minor[EW-1];
        nxt_x_o    = cur_x_i + one_c;
        if (minor_step) nxt_y_o = cur_y_i - one_c;
      end
      bol_pkg::OCT_SEVENTH: begin
        e_minor    = err_i + tdx_ext;
        e_major    = e_minor + tdy_ext;
        // seventh octant steps the minor axis on a strictly positive error
        minor_step = !e_minor[EW-1] && (e_minor != '0);
        nxt_y_o    = cur_y_i - one_c;
        if (minor_step) nxt_x_o = cur_x_i + one_c;
      end
      default: begin
        minor_step = 1'b0;
      end
    endcase
    nxt_err_o = minor_step ? e_major : e_minor;
  end

endmodule

`default_nettype wire

>>> verif/tb_bresenham_octant_line_stepper.sv
`timescale 1ns / 1ps

module tb_bresenham_octant_line_stepper;

  localparam int CB          = bol_pkg::COORD_BITS_DEF;
  localparam int DW          = CB + 1;
  localparam int TW          = CB + 2;
  localparam int EW          = CB + 3;
  localparam int CMAX        = (1 << CB) - 1;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    bol_pkg::op_e     op;
    logic [CB-1:0]    sx;
    logic [CB-1:0]    sy;
    logic [CB-1:0]    ex;
    logic [CB-1:0]    ey;
    bol_pkg::octant_e oct;
  } line_cmd_t;

  typedef struct {
    logic [CB-1:0]      px;
    logic [CB-1:0]      py;
    logic signed [CB:0] steps_left;
    logic signed [CB:0] span;
    logic               last;
  } pixel_t;

  logic clk_i;
  logic rst_ni;

  bol_in_if  #(.COORD_BITS(CB)) in_bus ();
  bol_out_if #(.COORD_BITS(CB)) out_bus ();

  bresenham_octant_line_stepper #(.COORD_BITS(CB)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // walker state mirrored by the predictor
  logic [CB-1:0]        wk_x, wk_y, wk_gx, wk_gy;
  logic signed [EW-1:0] wk_err;
  logic signed [TW-1:0] wk_tdx, wk_tdy;
  bol_pkg::octant_e     wk_oct;
  bit                   wk_busy;

  pixel_t pending_pixels[$];
  int     cmds_sent;
  int     fail_cnt;
  bit     tx_idle_en;
  bit     rx_idle_en;
  bit     hold_req;
  int     quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit walker_on_line();
    case (wk_oct)
      bol_pkg::OCT_SECOND:  return wk_y < wk_gy;
      bol_pkg::OCT_SEVENTH: return wk_y > wk_gy;
      default:              return wk_x < wk_gx;
    endcase
  endfunction

  // applies one command to the mirrored walker, returns 1 when a pixel comes out
  function automatic bit walk_line(input line_cmd_t c, output pixel_t p);
    int  dx;
    int  dy;
    bit  major_y;
    p = '{default: '0};
    if (c.op == bol_pkg::OP_START) begin
      wk_x   = c.sx;
      wk_y   = c.sy;
      wk_gx  = c.ex;
      wk_gy  = c.ey;
      wk_oct = c.oct;
      dx     = int'(wk_gx) - int'(wk_x);
      dy     = int'(wk_gy) - int'(wk_y);
      wk_tdx = TW'(2 * dx);
      wk_tdy = TW'(2 * dy);
      wk_err = EW'((wk_oct == bol_pkg::OCT_SECOND || wk_oct == bol_pkg::OCT_SEVENTH) ?
                   dy : dx);
      wk_busy = walker_on_line();
      return 1'b0;
    end
    if (!wk_busy) return 1'b0;

    major_y = (wk_oct == bol_pkg::OCT_SECOND || wk_oct == bol_pkg::OCT_SEVENTH);
    p.px = wk_x;
    p.py = wk_y;
    p.steps_left = DW'(major_y ? int'(wk_gy) - int'(wk_y) : int'(wk_gx) - int'(wk_x));
    p.span       = DW'(major_y ? int'(wk_tdy) / 2 : int'(wk_tdx) / 2);

    case (wk_oct)
      bol_pkg::OCT_FIRST: begin
        wk_x   = wk_x + 1'b1;
        wk_err = EW'(int'(wk_err) - int'(wk_tdy));
        if (wk_err < 0) begin
          wk_y   = wk_y + 1'b1;
          wk_err = EW'(int'(wk_err) + int'(wk_tdx));
        end
      end
      bol_pkg::OCT_SECOND: begin
        wk_y   = wk_y + 1'b1;
        wk_err = EW'(int'(wk_err) - int'(wk_tdx));
        if (wk_err < 0) begin
          wk_x   = wk_x + 1'b1;
          wk_err = EW'(int'(wk_err) + int'(wk_tdy));
        end
      end
      bol_pkg::OCT_EIGHTH: begin
        wk_x   = wk_x + 1'b1;
        wk_err = EW'(int'(wk_err) + int'(wk_tdy));
        if (wk_err < 0) begin
          wk_y   = wk_y - 1'b1;
          wk_err = EW'(int'(wk_err) + int'(wk_tdx));
        end
      end
      default: begin
        wk_y   = wk_y - 1'b1;
        wk_err = EW'(int'(wk_err) + int'(wk_tdx));
        if (wk_err > 0) begin
          wk_x   = wk_x + 1'b1;
          wk_err = EW'(int'(wk_err) + int'(wk_tdy));
        end
      end
    endcase

    wk_busy = walker_on_line();
    p.last  = !wk_busy;
    return 1'b1;
  endfunction

  function automatic line_cmd_t any_cmd();
    line_cmd_t c;
    c.op  = bol_pkg::op_e'($urandom_range(1));
    c.sx  = CB'($urandom_range(CMAX));
    c.sy  = CB'($urandom_range(CMAX));
    c.ex  = CB'($urandom_range(CMAX));
    c.ey  = CB'($urandom_range(CMAX));
    c.oct = bol_pkg::octant_e'($urandom_range(3));
    return c;
  endfunction

  function automatic line_cmd_t start_cmd(input int sx, input int sy, input int ex,
                                          input int ey, input bol_pkg::octant_e oct);
    line_cmd_t c;
    c.op  = bol_pkg::OP_START;
    c.sx  = CB'(sx);
    c.sy  = CB'(sy);
    c.ex  = CB'(ex);
    c.ey  = CB'(ey);
    c.oct = oct;
    return c;
  endfunction

  // drives one transaction and predicts its pixel once it is taken
  task automatic send_item(input line_cmd_t c);
    pixel_t p;
    bit     produced;
    while (tx_idle_en && $urandom_range(99) < 6) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.opcode  <= c.op;
    in_bus.start_x <= c.sx;
    in_bus.start_y <= c.sy;
    in_bus.end_x   <= c.ex;
    in_bus.end_y   <= c.ey;
    in_bus.octant  <= c.oct;
    do @(posedge clk_i); while (!in_bus.ready);
    produced = walk_line(c, p);
    if (produced) pending_pixels.push_back(p);
    if (produced || c.op == bol_pkg::OP_START) cmds_sent++;
  endtask

  task automatic send_steps(input int n);
    line_cmd_t c;
    repeat (n) begin
      c = any_cmd();
      c.op = bol_pkg::OP_STEP;
      send_item(c);
    end
  endtask

  // always waits on the clock so valid is never lowered and raised in one step
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_pixels.size() != 0);
  endtask

  // mostly well-formed lines of the chosen octant, some arbitrary traffic
  task automatic send_line();
    line_cmd_t c;
    int        pick;
    int        major;
    int        minor;
    int        n;
    pick = int'($urandom_range(99));
    if (pick < 10) begin
      c = any_cmd();
      c.op = bol_pkg::OP_START;
      send_item(c);
      repeat ($urandom_range(10)) begin
        c = any_cmd();
        if ($urandom_range(99) < 80) c.op = bol_pkg::OP_STEP;
        send_item(c);
      end
    end else begin
      if (pick < 12)      major = 0;
      else if (pick < 15) major = int'($urandom_range(400, 100));
      else if (pick < 70) major = int'($urandom_range(12, 1));
      else                major = int'($urandom_range(60, 13));
      minor = int'($urandom_range(major, 0));
      c = any_cmd();
      c.op = bol_pkg::OP_START;
      case (c.oct)
        bol_pkg::OCT_FIRST: begin
          c.sx = CB'($urandom_range(CMAX - major));
          c.sy = CB'($urandom_range(CMAX - minor));
          c.ex = CB'(int'(c.sx) + major);
          c.ey = CB'(int'(c.sy) + minor);
        end
        bol_pkg::OCT_SECOND: begin
          c.sx = CB'($urandom_range(CMAX - minor));
          c.sy = CB'($urandom_range(CMAX - major));
          c.ex = CB'(int'(c.sx) + minor);
          c.ey = CB'(int'(c.sy) + major);
        end
        bol_pkg::OCT_EIGHTH: begin
          c.sx = CB'($urandom_range(CMAX - major));
          c.sy = CB'($urandom_range(CMAX, minor));
          c.ex = CB'(int'(c.sx) + major);
          c.ey = CB'(int'(c.sy) - minor);
        end
        default: begin
          c.sx = CB'($urandom_range(CMAX - minor));
          c.sy = CB'($urandom_range(CMAX, major));
          c.ex = CB'(int'(c.sx) + minor);
          c.ey = CB'(int'(c.sy) - major);
        end
      endcase
      send_item(c);
      // a few extra steps land on an idle walker, some lines are cut short
      n = major + int'($urandom_range(2));
      if ($urandom_range(99) < 10) n = int'($urandom_range(major));
      send_steps(n);
    end
  endtask

  task automatic test_directed();
    send_steps(1);
    send_item(start_cmd(0, 0, CMAX, CMAX, bol_pkg::OCT_FIRST));
    send_steps(2);
    // restart in the middle of the line above
    send_item(start_cmd(10, 10, 13, 17, bol_pkg::OCT_SECOND));
    send_steps(4);
    send_item(start_cmd(0, CMAX, CMAX, 0, bol_pkg::OCT_EIGHTH));
    send_steps(2);
    send_item(start_cmd(4000, CMAX, 4003, 4088, bol_pkg::OCT_SEVENTH));
    send_steps(3);
    // steep line under eighth-octant rules: error wraps and y wraps below zero
    send_item(start_cmd(0, 0, 3, CMAX, bol_pkg::OCT_EIGHTH));
    send_steps(3);
    send_item(start_cmd(100, 100, 100, 200, bol_pkg::OCT_FIRST));
    send_steps(1);
    send_item(start_cmd(5, 5, 5, 6, bol_pkg::OCT_SECOND));
    send_steps(2);
  endtask

  task automatic test_random_lines(input int upto);
    while (cmds_sent < upto) send_line();
  endtask

  task automatic test_output_hold();
    int stop_at;
    stop_at = cmds_sent + 150;
    hold_req <= 1'b1;
    while (cmds_sent < stop_at) send_line();
    wait_drained();
  endtask

  task automatic test_streaming(input int upto);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (cmds_sent < upto) send_line();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.opcode  = bol_pkg::OP_START;
    in_bus.start_x = '0;
    in_bus.start_y = '0;
    in_bus.end_x   = '0;
    in_bus.end_y   = '0;
    in_bus.octant  = bol_pkg::OCT_FIRST;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    hold_req       = 1'b0;
    cmds_sent      = 0;
    wk_x = '0; wk_y = '0; wk_gx = '0; wk_gy = '0;
    wk_err = '0; wk_tdx = '0; wk_tdy = '0;
    wk_oct = bol_pkg::OCT_FIRST;
    wk_busy = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_lines(750);
    test_output_hold();
    test_streaming(1400);
    test_random_lines(1950);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // pixel receiver: checks each transaction and throttles ready
  always @(posedge clk_i) begin : pixel_rx
    pixel_t want;
    bit     hold_done;
    int     hold_left;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_pixels.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected pixel, expected none", $time);
        $display("%0t:   got x=%0d y=%0d left=%0d span=%0d last=%0b",
                 $time, out_bus.pixel_x, out_bus.pixel_y, out_bus.steps_left,
                 out_bus.span, out_bus.last_pixel);
      end else begin
        want = pending_pixels.pop_front();
        if (out_bus.pixel_x !== want.px || out_bus.pixel_y !== want.py ||
            out_bus.steps_left !== want.steps_left || out_bus.span !== want.span ||
            out_bus.last_pixel !== want.last) begin
          fail_cnt++;
          $display("%0t: pixel mismatch, expected x=%0d y=%0d left=%0d span=%0d last=%0b",
                   $time, want.px, want.py, want.steps_left, want.span, want.last);
          $display("%0t:                 got      x=%0d y=%0d left=%0d span=%0d last=%0b",
                   $time, out_bus.pixel_x, out_bus.pixel_y, out_bus.steps_left,
                   out_bus.span, out_bus.last_pixel);
        end
      end
    end
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= !(rx_idle_en && $urandom_range(99) < 6);
    end
  end

  // ends the run when neither channel has moved for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> sim.f
hdl/bol_pkg.sv
hdl/bol_in_if.sv
hdl/bol_out_if.sv
hdl/bol_step.sv
hdl/bresenham_octant_line_stepper.sv
verif/tb_bresenham_octant_line_stepper.sv
